>>> rtl/core/strp_pkg.sv
`default_nettype none

package strp_pkg;

    localparam int TILE_PIXELS   = 8;
    localparam int TILE_SHIFT    = $clog2(TILE_PIXELS);
    localparam int MAX_MAP_TILES = 64;
    localparam int MAX_SCREEN    = 512;

    localparam int COL_W    = 6;
    localparam int TILES_W  = 7;
    localparam int SCROLL_W = 16;
    localparam int SCR_W    = 10;
    localparam int PIX_W    = 10;
    localparam int POS_W    = 9;
    localparam int LEN_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int DIV_STEPS = SCROLL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;

    localparam logic [TILES_W-1:0] MAP_WIDTH_RST     = 7'd64;
    localparam logic [TILES_W-1:0] MAP_HEIGHT_RST    = 7'd32;
    localparam logic [SCR_W-1:0]   SCREEN_WIDTH_RST  = 10'd256;
    localparam logic [SCR_W-1:0]   SCREEN_HEIGHT_RST = 10'd224;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic scan_init;
        logic scan_step;
        logic emit_load;
    } strp_cmd_t;

    typedef struct packed {
        logic ok;
        logic div_last;
        logic scan_last;
        logic emit_last;
        logic out_free;
    } strp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/strp_ctrl.sv
`default_nettype none

module strp_ctrl
    import strp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire strp_sts_t sts,
    output logic           in_stall,
    output strp_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_INIT = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!sts.ok)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/strp_axis.sv
`default_nettype none

module strp_axis
    import strp_pkg::*;
#(
    parameter logic PHASE = 1'b0
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic [SCROLL_W-1:0] scroll,
    input  wire logic                div_step,
    input  wire logic [PIX_W-1:0]    per,
    input  wire logic                scan_init,
    input  wire logic                scan_step,
    input  wire logic [POS_W-1:0]    pos,
    input  wire logic [SCR_W-1:0]    vis,
    input  wire logic [COL_W-1:0]    start,
    input  wire logic [TILES_W-1:0]  len,
    input  wire logic                sel,
    output logic                     none,
    output logic                     two,
    output logic [POS_W-1:0]         sel_start,
    output logic [LEN_W-1:0]         sel_len
);

    localparam int E_W = PIX_W + 1;

    logic [SCROLL_W-1:0] dvd_reg;
    logic [PIX_W-1:0]    rem_reg;
    logic [PIX_W-1:0]    w_reg;
    logic [1:0]          cnt_reg;
    logic                act_reg;
    logic                fail_reg;
    logic [POS_W-1:0]    st_reg [2];
    logic [LEN_W-1:0]    ln_reg [2];

    logic [PIX_W:0]   trial;
    logic [PIX_W-1:0] rem_next;
    logic [PIX_W:0]   w0_sum;
    logic [PIX_W-1:0] w0;
    logic [PIX_W-1:0] w_next;
    logic [PIX_W-1:0] s_pix;
    logic [E_W-1:0]   e_pix;
    logic             active;
    logic             hit;
    logic [1:0]       runs;

    // one quotient bit per step, restoring
    always_comb
    begin
        trial = {rem_reg, dvd_reg[SCROLL_W-1]};
        if (trial >= {1'b0, per})
        begin
            rem_next = PIX_W'(trial - {1'b0, per});
        end
        else
        begin
            rem_next = trial[PIX_W-1:0];
        end
    end

    always_comb
    begin
        w0_sum = {1'b0, rem_reg} + {{PIX_W{1'b0}}, PHASE};
        if (w0_sum >= {1'b0, per})
        begin
            w0 = PIX_W'(w0_sum - {1'b0, per});
        end
        else
        begin
            w0 = w0_sum[PIX_W-1:0];
        end
    end

    assign w_next = (w_reg == per - PIX_W'(1)) ? '0 : w_reg + PIX_W'(1);
    assign s_pix  = PIX_W'(start) << TILE_SHIFT;
    assign e_pix  = (E_W'(start) + E_W'(len)) << TILE_SHIFT;
    assign active = ({1'b0, pos} < vis);
    assign hit    = (w_reg >= s_pix) && ({1'b0, w_reg} < e_pix);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= scroll;
            rem_reg <= '0;
        end
        else if (div_step)
        begin
            dvd_reg <= {dvd_reg[SCROLL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (scan_init)
        begin
            w_reg <= w0;
        end
        else if (scan_step && active)
        begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            act_reg  <= 1'b0;
            fail_reg <= 1'b0;
        end
        else if (scan_init)
        begin
            cnt_reg  <= '0;
            act_reg  <= 1'b0;
            fail_reg <= 1'b0;
        end
        else if (scan_step && active && !fail_reg)
        begin
            if (hit && !act_reg)
            begin
                if (cnt_reg[1])
                begin
                    fail_reg <= 1'b1;
                end
                else
                begin
                    act_reg <= 1'b1;
                end
            end
            else if (!hit && act_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_step && active && !fail_reg && !cnt_reg[1])
        begin
            if (hit && !act_reg)
            begin
                st_reg[cnt_reg[0]] <= pos;
                ln_reg[cnt_reg[0]] <= LEN_W'(1);
            end
            else if (hit)
            begin
                ln_reg[cnt_reg[0]] <= ln_reg[cnt_reg[0]] + LEN_W'(1);
            end
        end
    end

    assign runs      = cnt_reg + {1'b0, act_reg};
    assign none      = fail_reg || (runs == 2'd0);
    assign two       = (runs == 2'd2);
    assign sel_start = st_reg[sel];
    assign sel_len   = ln_reg[sel];

endmodule

`default_nettype wire

>>> rtl/core/strp_datapath.sv
`default_nettype none

module strp_datapath
    import strp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire strp_cmd_t           cmd,
    output strp_sts_t                sts,
    input  wire logic [TILES_W-1:0]  map_cols,
    input  wire logic [TILES_W-1:0]  map_rows,
    input  wire logic [SCR_W-1:0]    screen_width,
    input  wire logic [SCR_W-1:0]    screen_height,
    input  wire logic [COL_W-1:0]    tile_col,
    input  wire logic [COL_W-1:0]    tile_row,
    input  wire logic [TILES_W-1:0]  tile_cols,
    input  wire logic [TILES_W-1:0]  tile_rows,
    input  wire logic [SCROLL_W-1:0] scroll_x,
    input  wire logic [SCROLL_W-1:0] scroll_y,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [POS_W-1:0]         rect_x,
    output logic [POS_W-1:0]         rect_y,
    output logic [LEN_W-1:0]         rect_w,
    output logic [LEN_W-1:0]         rect_h,
    output logic                     is_empty,
    output logic                     is_last
);

    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     row_reg;
    logic [TILES_W-1:0]   cols_reg;
    logic [TILES_W-1:0]   rows_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 xi_reg;
    logic                 yi_reg;
    logic                 out_valid_reg;
    logic [POS_W-1:0]     rect_x_reg;
    logic [POS_W-1:0]     rect_y_reg;
    logic [LEN_W-1:0]     rect_w_reg;
    logic [LEN_W-1:0]     rect_h_reg;
    logic                 is_empty_reg;
    logic                 is_last_reg;

    logic             ok;
    logic [SCR_W-1:0] max_vis;
    logic [PIX_W-1:0] per_x;
    logic [PIX_W-1:0] per_y;
    logic             h_none;
    logic             h_two;
    logic             v_none;
    logic             v_two;
    logic [POS_W-1:0] h_st;
    logic [POS_W-1:0] v_st;
    logic [LEN_W-1:0] h_ln;
    logic [LEN_W-1:0] v_ln;
    logic             last_x;
    logic             last_y;
    logic             empty;
    logic             out_free;

    assign ok = (cols_reg != '0) && (rows_reg != '0)
             && (map_cols != '0) && (map_rows != '0)
             && (map_cols <= TILES_W'(MAX_MAP_TILES))
             && (map_rows <= TILES_W'(MAX_MAP_TILES))
             && ((TILES_W+1)'(col_reg) + (TILES_W+1)'(cols_reg)
                 <= (TILES_W+1)'(map_cols))
             && ((TILES_W+1)'(row_reg) + (TILES_W+1)'(rows_reg)
                 <= (TILES_W+1)'(map_rows))
             && (screen_width != '0) && (screen_height != '0)
             && (screen_width <= SCR_W'(MAX_SCREEN))
             && (screen_height <= SCR_W'(MAX_SCREEN));

    assign max_vis = (screen_width > screen_height) ? screen_width : screen_height;
    assign per_x   = PIX_W'(map_cols) << TILE_SHIFT;
    assign per_y   = PIX_W'(map_rows) << TILE_SHIFT;

    strp_axis #(
        .PHASE(1'b0)
    ) u_axis_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.capture),
        .scroll    (scroll_x),
        .div_step  (cmd.div_step),
        .per       (per_x),
        .scan_init (cmd.scan_init),
        .scan_step (cmd.scan_step),
        .pos       (pos_reg),
        .vis       (screen_width),
        .start     (col_reg),
        .len       (cols_reg),
        .sel       (xi_reg),
        .none      (h_none),
        .two       (h_two),
        .sel_start (h_st),
        .sel_len   (h_ln)
    );

    strp_axis #(
        .PHASE(1'b1)
    ) u_axis_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.capture),
        .scroll    (scroll_y),
        .div_step  (cmd.div_step),
        .per       (per_y),
        .scan_init (cmd.scan_init),
        .scan_step (cmd.scan_step),
        .pos       (pos_reg),
        .vis       (screen_height),
        .start     (row_reg),
        .len       (rows_reg),
        .sel       (yi_reg),
        .none      (v_none),
        .two       (v_two),
        .sel_start (v_st),
        .sel_len   (v_ln)
    );

    assign last_x   = !h_two || xi_reg;
    assign last_y   = !v_two || yi_reg;
    assign empty    = !ok || h_none || v_none;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts           = '0;
        sts.ok        = ok;
        sts.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        sts.scan_last = ({1'b0, pos_reg} == max_vis - SCR_W'(1));
        sts.emit_last = empty || (last_x && last_y);
        sts.out_free  = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg  <= tile_col;
            row_reg  <= tile_row;
            cols_reg <= tile_cols;
            rows_reg <= tile_rows;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            pos_reg     <= '0;
            xi_reg      <= 1'b0;
            yi_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.scan_init)
            begin
                pos_reg <= '0;
                xi_reg  <= 1'b0;
                yi_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            else if (cmd.emit_load && !empty)
            begin
                if (last_x)
                begin
                    xi_reg <= 1'b0;
                    yi_reg <= 1'b1;
                end
                else
                begin
                    xi_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            if (empty)
            begin
                rect_x_reg   <= '0;
                rect_y_reg   <= '0;
                rect_w_reg   <= '0;
                rect_h_reg   <= '0;
                is_empty_reg <= 1'b1;
                is_last_reg  <= 1'b1;
            end
            else
            begin
                rect_x_reg   <= h_st;
                rect_y_reg   <= v_st;
                rect_w_reg   <= h_ln;
                rect_h_reg   <= v_ln;
                is_empty_reg <= 1'b0;
                is_last_reg  <= last_x && last_y;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign rect_x    = rect_x_reg;
    assign rect_y    = rect_y_reg;
    assign rect_w    = rect_w_reg;
    assign rect_h    = rect_h_reg;
    assign is_empty  = is_empty_reg;
    assign is_last   = is_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/scrolled_tile_region_projector.sv
// Projects one tile region of a wrapping tilemap onto the screen.
// Input channel: in_valid / in_stall, a transfer carries the region in tiles
// and both scroll offsets. Output channel: out_valid / out_stall, each
// transfer carries one screen rectangle; is_last marks the final rectangle of
// a request, is_empty marks the single result of a request that projects
// to nothing. Rectangles come rows outer, columns inner, up to four.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// map width, map height, screen width, screen height; other indexes are
// dropped. Write config only while the block is idle.
// Steps: the request is captured, both scrolls are reduced modulo the map
// (one quotient bit per cycle, both axes in parallel), a setup state runs,
// then the screen positions below max(screen_width, screen_height) are
// scanned, one per cycle on both axes, then the results are loaded into
// the output register in order, each waiting while the output stalls.
// An invalid request skips the reduction and the scan.
// One request is worked on at a time; the next is taken once the last
// result sits in the output register.
// Reset loads the default map and screen sizes and empties the output.
// A stalled output holds its result and delays the remaining ones.
`default_nettype none

module scrolled_tile_region_projector
    import strp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [COL_W-1:0]      tile_col,
    input  wire logic [COL_W-1:0]      tile_row,
    input  wire logic [TILES_W-1:0]    tile_cols,
    input  wire logic [TILES_W-1:0]    tile_rows,
    input  wire logic [SCROLL_W-1:0]   scroll_x,
    input  wire logic [SCROLL_W-1:0]   scroll_y,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [POS_W-1:0]           rect_x,
    output logic [POS_W-1:0]           rect_y,
    output logic [LEN_W-1:0]           rect_w,
    output logic [LEN_W-1:0]           rect_h,
    output logic                       is_empty,
    output logic                       is_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TILES_W-1:0] map_width_reg;
    logic [TILES_W-1:0] map_height_reg;
    logic [SCR_W-1:0]   screen_width_reg;
    logic [SCR_W-1:0]   screen_height_reg;

    strp_cmd_t cmd;
    strp_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg     <= MAP_WIDTH_RST;
            map_height_reg    <= MAP_HEIGHT_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:     map_width_reg     <= cfg_data[TILES_W-1:0];
                REG_MAP_HEIGHT:    map_height_reg    <= cfg_data[TILES_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SCR_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SCR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    strp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    strp_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .map_cols         (map_width_reg),
        .map_rows         (map_height_reg),
        .screen_width     (screen_width_reg),
        .screen_height    (screen_height_reg),
        .tile_col         (tile_col),
        .tile_row         (tile_row),
        .tile_cols        (tile_cols),
        .tile_rows        (tile_rows),
        .scroll_x         (scroll_x),
        .scroll_y         (scroll_y),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .rect_x           (rect_x),
        .rect_y           (rect_y),
        .rect_w           (rect_w),
        .rect_h           (rect_h),
        .is_empty         (is_empty),
        .is_last          (is_last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transfer");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> is_last)
        else $error("empty result not marked last");

    a_empty_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |->
            (rect_x == '0 && rect_y == '0 && rect_w == '0 && rect_h == '0))
        else $error("empty result carries a rectangle");

    a_rect_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_empty) |-> (rect_w != '0 && rect_h != '0))
        else $error("rectangle with zero size");

endmodule

`default_nettype wire

>>> tb/strp_projection_checker.sv
`timescale 1ns / 100ps

module strp_projection_checker
    import strp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [COL_W-1:0]      tile_col,
    input  wire logic [COL_W-1:0]      tile_row,
    input  wire logic [TILES_W-1:0]    tile_cols,
    input  wire logic [TILES_W-1:0]    tile_rows,
    input  wire logic [SCROLL_W-1:0]   scroll_x,
    input  wire logic [SCROLL_W-1:0]   scroll_y,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [POS_W-1:0]      rect_x,
    input  wire logic [POS_W-1:0]      rect_y,
    input  wire logic [LEN_W-1:0]      rect_w,
    input  wire logic [LEN_W-1:0]      rect_h,
    input  wire logic                  is_empty,
    input  wire logic                  is_last,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding,
    output int                         rects_seen
);

    typedef struct packed {
        logic [1:0]  count;
        logic [9:0]  start0;
        logic [9:0]  start1;
        logic [10:0] len0;
        logic [10:0] len1;
    } axis_span_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [LEN_W-1:0] w;
        logic [LEN_W-1:0] h;
        logic             blank;
        logic             last;
    } rect_t;

    logic [TILES_W-1:0] map_w;
    logic [TILES_W-1:0] map_h;
    logic [SCR_W-1:0]   scr_w;
    logic [SCR_W-1:0]   scr_h;

    rect_t pending_rects[$];
    rect_t want;

    function automatic bit covers(input int unsigned w, s, len, per);
        int unsigned e;
        if (len >= per)
            return 1'b1;
        e = s + len;
        if (e <= per)
            return (w >= s) && (w < e);
        return (w >= s) || (w < e - per);
    endfunction

    // third run gives a count of zero
    function automatic axis_span_t find_runs(input int unsigned rs, rl, per, scr, phase, vis);
        axis_span_t r;
        int unsigned p;
        int unsigned w;
        bit hit;
        bit open;
        r = '0;
        open = 1'b0;
        for (p = 0; p < vis; p++)
        begin
            w = (p + scr + phase) % per;
            hit = covers(w, rs, rl, per);
            if (hit && !open)
            begin
                if (r.count >= 2)
                begin
                    r.count = 0;
                    return r;
                end
                if (r.count == 0)
                begin
                    r.start0 = p;
                    r.len0 = 1;
                end
                else
                begin
                    r.start1 = p;
                    r.len1 = 1;
                end
                open = 1'b1;
            end
            else if (hit)
            begin
                if (r.count == 0)
                    r.len0 = r.len0 + 1;
                else
                    r.len1 = r.len1 + 1;
            end
            else if (open)
            begin
                r.count = r.count + 1;
                open = 1'b0;
            end
        end
        if (open)
            r.count = r.count + 1;
        return r;
    endfunction

    task automatic project_region(input int unsigned col, row, cols, rows, sx, sy);
        axis_span_t h;
        axis_span_t v;
        rect_t r;
        int unsigned mw_px;
        int unsigned mh_px;
        int unsigned xi;
        int unsigned yi;
        bit ok;
        ok = cols != 0 && rows != 0 && map_w != 0 && map_h != 0 &&
             map_w <= MAX_MAP_TILES && map_h <= MAX_MAP_TILES &&
             col + cols <= map_w && row + rows <= map_h &&
             scr_w != 0 && scr_h != 0 && scr_w <= MAX_SCREEN && scr_h <= MAX_SCREEN;
        h = '0;
        v = '0;
        if (ok)
        begin
            mw_px = map_w * TILE_PIXELS;
            mh_px = map_h * TILE_PIXELS;
            h = find_runs(col * TILE_PIXELS, cols * TILE_PIXELS, mw_px, sx % mw_px, 0, scr_w);
            v = find_runs(row * TILE_PIXELS, rows * TILE_PIXELS, mh_px, sy % mh_px, 1, scr_h);
            ok = h.count != 0 && v.count != 0;
        end
        if (!ok)
        begin
            r = '0;
            r.blank = 1'b1;
            r.last = 1'b1;
            pending_rects.push_back(r);
        end
        else
        begin
            for (yi = 0; yi < v.count; yi++)
            begin
                for (xi = 0; xi < h.count; xi++)
                begin
                    r.x = (xi != 0) ? h.start1[POS_W-1:0] : h.start0[POS_W-1:0];
                    r.y = (yi != 0) ? v.start1[POS_W-1:0] : v.start0[POS_W-1:0];
                    r.w = (xi != 0) ? h.len1[LEN_W-1:0] : h.len0[LEN_W-1:0];
                    r.h = (yi != 0) ? v.len1[LEN_W-1:0] : v.len0[LEN_W-1:0];
                    r.blank = 1'b0;
                    r.last = (yi + 1 == v.count) && (xi + 1 == h.count);
                    pending_rects.push_back(r);
                end
            end
        end
    endtask

    function automatic int field_differs(input string label, input int unsigned exp_v, act_v);
        if (exp_v == act_v)
            return 0;
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, label, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w = MAP_WIDTH_RST;
            map_h = MAP_HEIGHT_RST;
            scr_w = SCREEN_WIDTH_RST;
            scr_h = SCREEN_HEIGHT_RST;
            pending_rects.delete();
            mismatches = 0;
            outstanding = 0;
            rects_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:     map_w = cfg_data[TILES_W-1:0];
                    REG_MAP_HEIGHT:    map_h = cfg_data[TILES_W-1:0];
                    REG_SCREEN_WIDTH:  scr_w = cfg_data[SCR_W-1:0];
                    REG_SCREEN_HEIGHT: scr_h = cfg_data[SCR_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                rects_seen++;
                if (pending_rects.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual x=%0d y=%0d w=%0d h=%0d empty=%0d last=%0d",
                             $time, rect_x, rect_y, rect_w, rect_h, is_empty, is_last);
                    mismatches++;
                end
                else
                begin
                    want = pending_rects.pop_front();
                    mismatches += field_differs("rect_x", want.x, rect_x)
                                + field_differs("rect_y", want.y, rect_y)
                                + field_differs("rect_w", want.w, rect_w)
                                + field_differs("rect_h", want.h, rect_h)
                                + field_differs("is_empty", want.blank, is_empty)
                                + field_differs("is_last", want.last, is_last);
                end
            end
            if (in_valid && !in_stall)
                project_region(tile_col, tile_row, tile_cols, tile_rows, scroll_x, scroll_y);
            outstanding = pending_rects.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import strp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 600;
    localparam int IDLE_PCT     = 33;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COL_W-1:0]      tile_col = '0;
    logic [COL_W-1:0]      tile_row = '0;
    logic [TILES_W-1:0]    tile_cols = '0;
    logic [TILES_W-1:0]    tile_rows = '0;
    logic [SCROLL_W-1:0]   scroll_x = '0;
    logic [SCROLL_W-1:0]   scroll_y = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [POS_W-1:0]      rect_x;
    logic [POS_W-1:0]      rect_y;
    logic [LEN_W-1:0]      rect_w;
    logic [LEN_W-1:0]      rect_h;
    logic                  is_empty;
    logic                  is_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int rects_seen;

    bit calm = 1'b0;
    int requests = 0;
    int settings = 0;
    int cycle_count = 0;
    int phase;
    int k;
    int cur_mw = 64;
    int cur_mh = 32;
    logic [9:0] nw, nh, nsw, nsh;

    scrolled_tile_region_projector dut (.*);

    strp_projection_checker proj_check (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99, 0) < IDLE_PCT);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_request(input logic [COL_W-1:0] col, row,
                                input logic [TILES_W-1:0] cols, rows,
                                input logic [SCROLL_W-1:0] sx, sy);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        tile_col <= col;
        tile_row <= row;
        tile_cols <= cols;
        tile_rows <= rows;
        scroll_x <= sx;
        scroll_y <= sy;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        requests++;
    endtask

    // four register writes, then one to an unused index
    task automatic set_sizes(input logic [9:0] mw, mh, sw, sh);
        int n;
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        for (n = 0; n < 5; n++)
        begin
            case (n)
                0: begin cfg_index <= REG_MAP_WIDTH;     cfg_data <= mw; end
                1: begin cfg_index <= REG_MAP_HEIGHT;    cfg_data <= mh; end
                2: begin cfg_index <= REG_SCREEN_WIDTH;  cfg_data <= sw; end
                3: begin cfg_index <= REG_SCREEN_HEIGHT; cfg_data <= sh; end
                default:
                begin
                    cfg_index <= CFG_IDX_W'($urandom_range(7, 4));
                    cfg_data <= CFG_DATA_W'($urandom);
                end
            endcase
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        cur_mw = mw[TILES_W-1:0];
        cur_mh = mh[TILES_W-1:0];
        settings++;
    endtask

    task automatic random_request();
        logic [COL_W-1:0] col, row;
        logic [TILES_W-1:0] cols, rows;
        if (cur_mw >= 1 && cur_mw <= MAX_MAP_TILES && $urandom_range(99, 0) >= 15)
        begin
            col = COL_W'($urandom_range(cur_mw - 1, 0));
            cols = TILES_W'($urandom_range(cur_mw - col, 1));
        end
        else
        begin
            col = COL_W'($urandom_range(63, 0));
            cols = TILES_W'($urandom_range(64, 0));
        end
        if (cur_mh >= 1 && cur_mh <= MAX_MAP_TILES && $urandom_range(99, 0) >= 15)
        begin
            row = COL_W'($urandom_range(cur_mh - 1, 0));
            rows = TILES_W'($urandom_range(cur_mh - row, 1));
        end
        else
        begin
            row = COL_W'($urandom_range(63, 0));
            rows = TILES_W'($urandom_range(64, 0));
        end
        send_request(col, row, cols, rows, SCROLL_W'($urandom), SCROLL_W'($urandom));
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sizes: 64x32 map, 256x224 screen
        send_request(0, 0, 64, 32, 0, 0);
        send_request(0, 0, 0, 5, 0, 0);
        send_request(0, 0, 5, 0, 0, 0);
        send_request(63, 31, 1, 1, 16'hFFFF, 16'hFFFF);
        send_request(63, 0, 2, 1, 0, 0);
        send_request(0, 31, 1, 2, 0, 0);
        send_request(40, 0, 4, 4, 0, 0);
        send_request(0, 0, 1, 1, 0, 255);
        send_request(1, 0, 64, 1, 7, 9);

        // two runs on each axis, four rectangles, then a corner tile with one run per axis
        set_sizes(32, 32, 256, 256);
        send_request(0, 0, 1, 1, 4, 4);
        send_request(0, 0, 1, 1, 4, 0);
        send_request(31, 31, 1, 1, 0, 0);

        // small map repeats across the screen
        set_sizes(8, 8, 256, 256);
        send_request(0, 0, 1, 1, 0, 0);
        send_request(0, 0, 8, 8, 123, 77);

        set_sizes(64, 64, 512, 512);
        send_request(0, 0, 64, 64, 16'hFFFF, 0);
        send_request(63, 63, 1, 1, 16'h8000, 16'h7FFF);
        send_request(10, 20, 30, 40, 1000, 2000);

        set_sizes(0, 32, 256, 224);
        send_request(0, 0, 1, 1, 0, 0);
        set_sizes(64, 0, 256, 224);
        send_request(0, 0, 1, 1, 0, 0);
        set_sizes(64, 32, 0, 224);
        send_request(0, 0, 1, 1, 0, 0);
        set_sizes(64, 32, 256, 0);
        send_request(0, 0, 1, 1, 0, 0);
        set_sizes(65, 127, 513, 1023);
        send_request(0, 0, 1, 1, 0, 0);
        set_sizes(64, 64, 1, 1);
        send_request(0, 0, 64, 64, 0, 0);
        send_request(5, 5, 1, 1, 40, 39);

        for (phase = 0; phase < 16; phase++)
        begin
            calm = (phase == 6 || phase == 7);
            nw = 10'($urandom_range(64, 1));
            nh = 10'($urandom_range(64, 1));
            nsw = ($urandom_range(1, 0) != 0) ? 10'($urandom_range(128, 1))
                                              : 10'($urandom_range(512, 1));
            nsh = ($urandom_range(1, 0) != 0) ? 10'($urandom_range(128, 1))
                                              : 10'($urandom_range(512, 1));
            if (phase == 0)
            begin
                nw = 64;
                nh = 64;
                nsw = 512;
                nsh = 512;
            end
            else if (phase == 1)
            begin
                nw = 1;
                nh = 1;
                nsw = 1;
                nsh = 1;
            end
            else if ($urandom_range(7, 0) == 0)
            begin
                case ($urandom_range(3, 0))
                    0: nw = ($urandom_range(1, 0) != 0) ? 10'd0
                                                        : 10'($urandom_range(127, 65));
                    1: nh = ($urandom_range(1, 0) != 0) ? 10'd0
                                                        : 10'($urandom_range(127, 65));
                    2: nsw = ($urandom_range(1, 0) != 0) ? 10'd0
                                                         : 10'($urandom_range(1023, 513));
                    default: nsh = ($urandom_range(1, 0) != 0) ? 10'd0
                                                               : 10'($urandom_range(1023, 513));
                endcase
            end
            set_sizes(nw, nh, nsw, nsh);
            for (k = 0; k < 20; k++)
                random_request();
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d requests under %0d size settings, %0d rectangles checked",
                 requests, settings + 1, rects_seen);
        $display("directed corner regions, wraps, empty cases, then random regions and scrolls");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> scrolled_tile_region_projector.f
rtl/core/strp_pkg.sv
rtl/core/strp_ctrl.sv
rtl/core/strp_axis.sv
rtl/core/strp_datapath.sv
rtl/core/scrolled_tile_region_projector.sv
tb/strp_projection_checker.sv
tb/testbench.sv
